// ----- hdl/ppi_port_interface_assert.svh -----
// ----------------------------------------------------------------------------
// PPI port interface assertion macros
// Shared concurrent check forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef PPI_PORT_INTERFACE_ASSERT_SVH
`define PPI_PORT_INTERFACE_ASSERT_SVH

// Same-cycle implication.
`define PPI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PPI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/ppi_pkg.sv -----
// ----------------------------------------------------------------------------
// PPI package
// Address decode values, control word fields, register indexes and the
// packed layouts of one access and one result.
// ----------------------------------------------------------------------------
package ppi_pkg;

	localparam logic [7:0] ADDR_PORT_A = 8'hF4;
	localparam logic [7:0] ADDR_PORT_B = 8'hF5;
	localparam logic [7:0] ADDR_PORT_C = 8'hF6;
	localparam logic [7:0] ADDR_CTRL   = 8'hF7;

	// Direction bit positions, 1 = input
	localparam int unsigned DIR_A  = 3;
	localparam int unsigned DIR_B  = 2;
	localparam int unsigned DIR_CH = 1;
	localparam int unsigned DIR_CL = 0;
	localparam logic [3:0]  DIR_RESET = 4'hF;

	// Control word: bit 7 set selects a mode set, clear a bit set/reset
	localparam int unsigned CW_MODE_SET = 7;

	// Port C bits 7..6 drive the sound-chip bus function
	typedef enum logic [1:0] {
		PSG_FN_INACTIVE = 2'b00,
		PSG_FN_READ     = 2'b01,
		PSG_FN_WRITE    = 2'b10,
		PSG_FN_SELECT   = 2'b11
	} psg_fn_t;

	typedef enum logic [1:0] {
		CFG_MANUFACTURER = 2'd0,
		CFG_REFRESH_50HZ = 2'd1,
		CFG_PRINTER_BUSY = 2'd2
	} cfg_index_t;

	localparam int unsigned CFG_DATA_W = 3;

	// One access, lowest field in the lowest bits (27 bits)
	typedef struct packed {
		logic       tape_motor_running;
		logic       tape_level;
		logic       vsync;
		logic [7:0] psg_read_data;
		logic [7:0] write_data;
		logic [7:0] address_high;
	} ppi_in_t;

	// One result, lowest field in the lowest bits (32 bits)
	typedef struct packed {
		logic [7:0] row_value;
		logic       row_select_strobe;
		logic       tape_write_level;
		logic       motor_on;
		logic       motor_update;
		logic [7:0] psg_bus_value;
		logic       psg_write_strobe;
		logic       psg_select_strobe;
		logic       psg_read_request;
		logic [7:0] read_data;
		logic       handled;
	} ppi_res_t;

	localparam int unsigned IN_W  = $bits(ppi_in_t);
	localparam int unsigned RES_W = $bits(ppi_res_t);

endpackage

// ----- hdl/ppi_port_interface.sv -----
// ----------------------------------------------------------------------------
// PPI port interface
// 8255-style parallel port (mode 0) on an I/O bus: ports A, B and C, control
// word and port C bit set/reset, with sound-chip, cassette and keyboard side
// effects of port C updates to the halves set as outputs.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave-side transaction is one I/O access. s_tuser carries the
//   direction (1 = OUT, 0 = IN), s_tdata the address high byte, write byte,
//   sound-chip read byte and the vsync, tape level and motor status levels.
//   Every access yields exactly one master-side transaction with the handled
//   flag, read byte and the strobes and values for the sound chip, cassette
//   motor and level, and keyboard row select.
//   The access lands in the input register when accepted and moves on to
//   the result register, raising m_tvalid, once that register is free.
//   Throughput: one access per cycle while m_tready is high; the decode,
//   latch update and read mux sit in one level of logic between the two
//   registers; the port latches load in the same cycle as the result.
//   Stall: while m_tready is low the result is held; one more access may wait
//   in the input register, after which s_tready drops.
//   Reset: port latches and cassette level clear, all ports become inputs,
//   configuration returns to manufacturer code 7, 50 Hz and printer busy.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at the
//   clock edge and are meant to be issued while no access is in flight.
// ----------------------------------------------------------------------------
`include "ppi_port_interface_assert.svh"

module ppi_port_interface
	import ppi_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// slave side: one I/O access
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [7:0] address_high, [15:8] write_data, [23:16] psg_read_data,
	// [24] vsync, [25] tape_level, [26] tape_motor_running, [31:27] zero
	input  logic [31:0]           s_tdata,
	// [0] is_write
	input  logic                  s_tuser,
	// master side: one result
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] handled, [8:1] read_data, [9] psg_read_request,
	// [10] psg_select_strobe, [11] psg_write_strobe, [19:12] psg_bus_value,
	// [20] motor_update, [21] motor_on, [22] tape_write_level,
	// [23] row_select_strobe, [31:24] row_value
	output logic [31:0]           m_tdata,
	// configuration write port
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Input register
	logic     v_s1;
	ppi_in_t  in_s1;
	logic     wr_s1;

	// Result register
	logic     v_s2;
	ppi_res_t res_s2;

	// Port state
	logic [7:0] port_a_q;
	logic [7:0] port_b_q;
	logic [7:0] port_c_q;
	logic [3:0] dir_q;
	logic       lvl_q;

	// Configuration
	logic [2:0] manuf_q;
	logic       hz50_q;
	logic       busy_q;

	// Next state and result of the access in the input register
	logic [7:0] port_a_n;
	logic [7:0] port_b_n;
	logic [7:0] port_c_n;
	logic [3:0] dir_n;
	logic       lvl_n;
	logic       c_upd;
	psg_fn_t    psg_fn;
	ppi_res_t   res_n;

	logic adv;
	logic fire;

	// Result register frees up when empty or being taken
	assign adv      = !v_s2 || m_tready;
	assign fire     = v_s1 && adv;
	assign s_tready = !v_s1 || adv;
	assign m_tvalid = v_s2;
	assign m_tdata  = res_s2;

	// Capture the access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_s1 <= ppi_in_t'(s_tdata[IN_W-1:0]);
			wr_s1 <= s_tuser;
		end
	end

	// Decode, update the latches and form the result
	always_comb begin
		port_a_n = port_a_q;
		port_b_n = port_b_q;
		port_c_n = port_c_q;
		dir_n    = dir_q;
		lvl_n    = lvl_q;
		c_upd    = 1'b0;
		res_n    = '0;

		if (wr_s1) begin
			case (in_s1.address_high)
				ADDR_PORT_A: begin
					if (!dir_q[DIR_A]) begin
						port_a_n = in_s1.write_data;
					end
					res_n.handled = 1'b1;
				end
				ADDR_PORT_B: begin
					if (!dir_q[DIR_B]) begin
						port_b_n = in_s1.write_data;
					end
					res_n.handled = 1'b1;
				end
				ADDR_PORT_C: begin
					port_c_n      = in_s1.write_data;
					c_upd         = 1'b1;
					res_n.handled = 1'b1;
				end
				ADDR_CTRL: begin
					if (in_s1.write_data[CW_MODE_SET]) begin
						// Mode set: clear latches, load directions
						port_a_n = '0;
						port_b_n = '0;
						port_c_n = '0;
						dir_n    = {in_s1.write_data[4], in_s1.write_data[1],
						            in_s1.write_data[3], in_s1.write_data[0]};
					end else begin
						// Bit set/reset on port C
						port_c_n[in_s1.write_data[3:1]] = in_s1.write_data[0];
						c_upd = 1'b1;
					end
					res_n.handled = 1'b1;
				end
				default: begin
				end
			endcase
		end else begin
			case (in_s1.address_high)
				ADDR_PORT_A: begin
					if (dir_q[DIR_A]) begin
						if (psg_fn_t'(port_c_q[7:6]) == PSG_FN_READ) begin
							res_n.read_data        = in_s1.psg_read_data;
							res_n.psg_read_request = 1'b1;
						end else begin
							res_n.read_data = 8'hFF;
						end
					end else begin
						res_n.read_data = port_a_q;
					end
					res_n.handled = 1'b1;
				end
				ADDR_PORT_B: begin
					if (dir_q[DIR_B]) begin
						res_n.read_data = {in_s1.tape_level, busy_q, 1'b0, hz50_q,
						                   manuf_q, in_s1.vsync};
					end else begin
						res_n.read_data = port_b_q;
					end
					res_n.handled = 1'b1;
				end
				ADDR_PORT_C: begin
					if (dir_q[DIR_CH]) begin
						res_n.read_data = {port_c_q[7:6], 1'b0,
						                   in_s1.tape_motor_running, port_c_q[3:0]};
					end else begin
						res_n.read_data = 8'hFF;
					end
					res_n.handled = 1'b1;
				end
				default: begin
				end
			endcase
		end

		// Port C update: upper half drives sound chip, motor and cassette level
		psg_fn = psg_fn_t'(port_c_n[7:6]);
		if (c_upd && !dir_q[DIR_CH]) begin
			lvl_n              = port_c_n[5];
			res_n.motor_update = 1'b1;
			res_n.motor_on     = port_c_n[4];
			case (psg_fn)
				PSG_FN_SELECT: begin
					res_n.psg_select_strobe = 1'b1;
					res_n.psg_bus_value     = port_a_q;
				end
				PSG_FN_WRITE: begin
					res_n.psg_write_strobe = 1'b1;
					res_n.psg_bus_value    = port_a_q;
				end
				default: begin
				end
			endcase
		end
		// Lower half drives the keyboard row select
		if (c_upd && !dir_q[DIR_CL]) begin
			res_n.row_select_strobe = 1'b1;
			res_n.row_value         = port_c_n;
		end
		res_n.tape_write_level = lvl_n;
	end

	// Port state advances with each access that moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_a_q <= '0;
			port_b_q <= '0;
			port_c_q <= '0;
			dir_q    <= DIR_RESET;
			lvl_q    <= 1'b0;
		end else if (fire) begin
			port_a_q <= port_a_n;
			port_b_q <= port_b_n;
			port_c_q <= port_c_n;
			dir_q    <= dir_n;
			lvl_q    <= lvl_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_n;
		end
	end

	// Configuration registers; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manuf_q <= 3'd7;
			hz50_q  <= 1'b1;
			busy_q  <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index_t'(cfg_index))
				CFG_MANUFACTURER: manuf_q <= cfg_data[2:0];
				CFG_REFRESH_50HZ: hz50_q  <= cfg_data[0];
				CFG_PRINTER_BUSY: busy_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Checks
	`PPI_ASSERT_NOW(a_full_blocks_input, v_s1 && v_s2 && !m_tready, !s_tready, "input taken while both stages are full")
	`PPI_ASSERT_NOW(a_psg_strobes_excl, v_s2, !(res_s2.psg_select_strobe && res_s2.psg_write_strobe), "both sound-chip strobes in one result")
	`PPI_ASSERT_NOW(a_unhandled_quiet, v_s2 && !res_s2.handled, !(res_s2.motor_update || res_s2.row_select_strobe || res_s2.psg_read_request || (res_s2.read_data != 8'h00)), "side effect on an unhandled access")
	`PPI_ASSERT_NEXT(a_mode_set_clears, fire && wr_s1 && (in_s1.address_high == ADDR_CTRL) && in_s1.write_data[CW_MODE_SET], (port_a_q == 8'h00) && (port_b_q == 8'h00) && (port_c_q == 8'h00), "mode set left a port latch loaded")

endmodule

// ----- tb/ppi_port_interface_test.sv -----
// ----------------------------------------------------------------------------
// PPI port interface testbench
// Drives I/O accesses into the parallel port block over the slave stream,
// predicts every result from its own copy of the port latches, directions,
// cassette level and configuration, and compares each master-side result
// field by field. Directed accesses come first, then random traffic under
// several configuration settings, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module ppi_port_interface_test;
	import ppi_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// padding for the drain and end-of-run waits
	localparam int unsigned RESULT_LATENCY = 1;
	// longest correct silence is a long-stall receiver pattern plus a sender
	// gap; allow many times that before declaring the block hung
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned RANDOM_PHASE_ITEMS = 170;
	localparam int unsigned MAX_PRINTED = 100;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// [7:0] address_high, [15:8] write_data, [23:16] psg_read_data,
	// [24] vsync, [25] tape_level, [26] tape_motor_running, [31:27] zero
	logic [31:0]           s_tdata = '0;
	// [0] is_write
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// [0] handled, [8:1] read_data, [9] psg_read_request,
	// [10] psg_select_strobe, [11] psg_write_strobe, [19:12] psg_bus_value,
	// [20] motor_update, [21] motor_on, [22] tape_write_level,
	// [23] row_select_strobe, [31:24] row_value
	logic [31:0]           m_tdata;
	logic                  cfg_wr_en = 1'b0;
	logic [1:0]            cfg_index = CFG_MANUFACTURER;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ppi_port_interface uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Port model: latches, directions (1 = input), cassette level, config
	// ------------------------------------------------------------------------
	logic [7:0] port_a = '0;
	logic [7:0] port_b = '0;
	logic [7:0] port_c = '0;
	logic [3:0] port_dir = DIR_RESET;
	logic       cass_level = 1'b0;
	logic [2:0] cfg_mfr = 3'd7;
	logic       cfg_50hz = 1'b1;
	logic       cfg_busy = 1'b1;

	ppi_res_t pending_results[$];
	int unsigned mismatch_count = 0;

	// Side effects of any port C update: sound-chip strobes, motor and
	// cassette level through upper C, keyboard row through lower C.
	function automatic void apply_port_c(inout ppi_res_t r);
		if (!port_dir[DIR_CH]) begin
			cass_level = port_c[5];
			r.motor_update = 1'b1;
			r.motor_on = port_c[4];
			case (psg_fn_t'(port_c[7:6]))
				PSG_FN_SELECT: begin
					r.psg_select_strobe = 1'b1;
					r.psg_bus_value = port_a;
				end
				PSG_FN_WRITE: begin
					r.psg_write_strobe = 1'b1;
					r.psg_bus_value = port_a;
				end
				default: ;
			endcase
		end
		if (!port_dir[DIR_CL]) begin
			r.row_select_strobe = 1'b1;
			r.row_value = port_c;
		end
	endfunction

	// Advance the port model by one access and return the result it yields.
	function automatic ppi_res_t predict_access(ppi_in_t acc, logic wr);
		ppi_res_t r;
		logic [7:0] d;
		r = '0;
		d = acc.write_data;
		if (wr) begin
			case (acc.address_high)
				ADDR_PORT_A: begin
					if (!port_dir[DIR_A])
						port_a = d;
					r.handled = 1'b1;
				end
				ADDR_PORT_B: begin
					if (!port_dir[DIR_B])
						port_b = d;
					r.handled = 1'b1;
				end
				ADDR_PORT_C: begin
					// latch loads even when port C is an input
					port_c = d;
					apply_port_c(r);
					r.handled = 1'b1;
				end
				ADDR_CTRL: begin
					if (d[CW_MODE_SET]) begin
						// mode set: clear latches, load directions, no port C update
						port_a = '0;
						port_b = '0;
						port_c = '0;
						port_dir[DIR_A] = d[4];
						port_dir[DIR_B] = d[1];
						port_dir[DIR_CH] = d[3];
						port_dir[DIR_CL] = d[0];
					end else begin
						port_c[d[3:1]] = d[0];
						apply_port_c(r);
					end
					r.handled = 1'b1;
				end
				default: ;
			endcase
		end else begin
			case (acc.address_high)
				ADDR_PORT_A: begin
					if (!port_dir[DIR_A])
						r.read_data = port_a;
					else if (psg_fn_t'(port_c[7:6]) == PSG_FN_READ) begin
						r.read_data = acc.psg_read_data;
						r.psg_read_request = 1'b1;
					end else
						r.read_data = 8'hFF;
					r.handled = 1'b1;
				end
				ADDR_PORT_B: begin
					if (port_dir[DIR_B])
						r.read_data = {acc.tape_level, cfg_busy, 1'b0, cfg_50hz, cfg_mfr,
							acc.vsync};
					else
						r.read_data = port_b;
					r.handled = 1'b1;
				end
				ADDR_PORT_C: begin
					if (port_dir[DIR_CH])
						r.read_data = {port_c[7:6], 1'b0, acc.tape_motor_running, port_c[3:0]};
					else
						r.read_data = 8'hFF;
					r.handled = 1'b1;
				end
				// a read of the control address is not ours
				default: ;
			endcase
		end
		r.tape_write_level = cass_level;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Mismatch reporting and result checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatch_count < MAX_PRINTED)
			$display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch({"mismatch in ", name}, 32'(got), 32'(want));
	endtask

	// Sample at the edge, where every signal still holds its pre-edge value.
	always @(posedge clk) begin : result_check
		ppi_res_t got;
		ppi_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = ppi_res_t'(m_tdata);
			if (pending_results.size() == 0)
				report_mismatch("result with none expected", m_tdata, '0);
			else begin
				want = pending_results.pop_front();
				compare_field("handled", 8'(got.handled), 8'(want.handled));
				compare_field("read_data", got.read_data, want.read_data);
				compare_field("psg_read_request", 8'(got.psg_read_request),
					8'(want.psg_read_request));
				compare_field("psg_select_strobe", 8'(got.psg_select_strobe),
					8'(want.psg_select_strobe));
				compare_field("psg_write_strobe", 8'(got.psg_write_strobe),
					8'(want.psg_write_strobe));
				compare_field("psg_bus_value", got.psg_bus_value, want.psg_bus_value);
				compare_field("motor_update", 8'(got.motor_update), 8'(want.motor_update));
				compare_field("motor_on", 8'(got.motor_on), 8'(want.motor_on));
				compare_field("tape_write_level", 8'(got.tape_write_level),
					8'(want.tape_write_level));
				compare_field("row_select_strobe", 8'(got.row_select_strobe),
					8'(want.row_select_strobe));
				compare_field("row_value", got.row_value, want.row_value);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run when no transaction moves on either side
	// ------------------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: switch at random among four stall patterns
	// ------------------------------------------------------------------------
	int unsigned stall_mode = 0;
	int unsigned stall_left = 0;
	int unsigned stall_tick = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 80);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
			0: m_tready <= 1'b1;                          // no stalls
			1: m_tready <= 1'($urandom_range(0, 1));      // coin flip
			2: m_tready <= (stall_tick % 4) == 0;         // one in four
			default: m_tready <= (stall_tick % 32) < 8;   // long stalls
		endcase
	end

	// ------------------------------------------------------------------------
	// Sender: bursts of random length separated by random gaps
	// ------------------------------------------------------------------------
	int unsigned burst_left = 0;

	// Hold one access on the slave side until it is accepted, then record
	// the result it must produce.
	task automatic send_access(input ppi_in_t acc, input logic wr);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {{(32 - IN_W){1'b0}}, acc};
		s_tuser <= wr;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_access(acc, wr));
	endtask

	// OUT access; the unused inputs carry noise.
	task automatic port_write(logic [7:0] addr, logic [7:0] data);
		ppi_in_t acc;
		acc = ppi_in_t'(IN_W'($urandom));
		acc.address_high = addr;
		acc.write_data = data;
		send_access(acc, 1'b1);
	endtask

	// IN access with the external levels given; write_data carries noise.
	task automatic port_read(logic [7:0] addr, logic [7:0] psg, logic vs, logic tl,
		logic tm);
		ppi_in_t acc;
		acc = ppi_in_t'(IN_W'($urandom));
		acc.address_high = addr;
		acc.psg_read_data = psg;
		acc.vsync = vs;
		acc.tape_level = tl;
		acc.tape_motor_running = tm;
		send_access(acc, 1'b0);
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	// Write all three registers back to back; call only while idle.
	task automatic set_config(logic [2:0] mfr, logic hz, logic busy);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_MANUFACTURER;
		cfg_data <= mfr;
		@(posedge clk);
		cfg_index <= CFG_REFRESH_50HZ;
		cfg_data <= {2'b00, hz};
		@(posedge clk);
		cfg_index <= CFG_PRINTER_BUSY;
		cfg_data <= {2'b00, busy};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_mfr = mfr;
		cfg_50hz = hz;
		cfg_busy = busy;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// All ports input after reset: reads of B and C return status, A reads FF,
	// unknown addresses are ignored, a read of the control address is not handled.
	task automatic test_reset_state();
		port_read(ADDR_PORT_A, 8'h5A, 1'b0, 1'b0, 1'b0);
		port_read(ADDR_PORT_B, 8'h00, 1'b1, 1'b0, 1'b0);
		port_read(ADDR_PORT_C, 8'h00, 1'b0, 1'b1, 1'b1);
		port_read(ADDR_CTRL, 8'hFF, 1'b1, 1'b1, 1'b1);
		port_write(8'h00, 8'hFF);
		port_read(8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
	endtask

	// Port B status byte at the all-zero configuration and a mixed one, then back to the reset values.
	task automatic test_config_extremes();
		drain_pipeline();
		set_config(3'd0, 1'b0, 1'b0);
		port_read(ADDR_PORT_B, 8'h00, 1'b0, 1'b1, 1'b0);
		drain_pipeline();
		set_config(3'd5, 1'b0, 1'b1);
		port_read(ADDR_PORT_B, 8'h00, 1'b1, 1'b1, 1'b0);
		drain_pipeline();
		set_config(3'd7, 1'b1, 1'b1);
	endtask

	// Mode set words: all outputs, latch writes, port C strobes, then all
	// inputs where a write to A is dropped.
	task automatic test_mode_set();
		port_write(ADDR_CTRL, 8'h80);
		port_write(ADDR_PORT_A, 8'h3C);
		port_write(ADDR_PORT_B, 8'hA5);
		port_write(ADDR_PORT_C, 8'hC0);
		port_write(ADDR_PORT_C, 8'hB0);
		port_read(ADDR_PORT_A, 8'h00, 1'b0, 1'b0, 1'b0);
		port_read(ADDR_PORT_B, 8'h00, 1'b1, 1'b1, 1'b1);
		port_read(ADDR_PORT_C, 8'h00, 1'b0, 1'b0, 1'b1);
		port_write(ADDR_CTRL, 8'h9B);
		port_write(ADDR_PORT_A, 8'hFF);
	endtask

	// Bit set/reset on port C with A as input: sound-chip read, select,
	// and the cassette level.
	task automatic test_bit_set_reset();
		port_write(ADDR_CTRL, 8'h90);
		port_write(ADDR_CTRL, 8'h0D);
		port_read(ADDR_PORT_A, 8'hA5, 1'b0, 1'b0, 1'b0);
		port_write(ADDR_CTRL, 8'h0F);
		port_write(ADDR_CTRL, 8'h0E);
		port_write(ADDR_CTRL, 8'h0B);
	endtask

	// Mostly well-formed accesses to the four ports, some to any address.
	task automatic test_random_traffic(int unsigned count, logic [2:0] mfr, logic hz,
		logic busy);
		ppi_in_t acc;
		logic wr;
		drain_pipeline();
		set_config(mfr, hz, busy);
		repeat (count) begin
			acc = ppi_in_t'(IN_W'($urandom));
			if ($urandom_range(0, 99) >= 12)
				acc.address_high = 8'(ADDR_PORT_A + $urandom_range(0, 3));
			wr = $urandom_range(0, 99) < 60;
			// keep mode set words rarer than bit set/reset
			if (wr && acc.address_high == ADDR_CTRL)
				acc.write_data[CW_MODE_SET] = ($urandom_range(0, 3) == 0);
			send_access(acc, wr);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_config_extremes();
		test_mode_set();
		test_bit_set_reset();

		test_random_traffic(RANDOM_PHASE_ITEMS, 3'd0, 1'b0, 1'b0);
		test_random_traffic(RANDOM_PHASE_ITEMS, 3'd7, 1'b1, 1'b1);
		repeat (3)
			test_random_traffic(RANDOM_PHASE_ITEMS, 3'($urandom), 1'($urandom),
				1'($urandom));

		// let any stray result show up before the verdict
		drain_pipeline();
		repeat (4 * RESULT_LATENCY) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- ppi_port_interface.f -----
+incdir+hdl
hdl/ppi_pkg.sv
hdl/ppi_port_interface.sv
tb/ppi_port_interface_test.sv
